### hw/rtl/swb_pkg.sv
package swb_pkg;

  localparam int BufferDepth = 16;
  localparam int AddrCount   = 128;
  localparam int MaxErase    = 16;
  localparam int IdxW        = $clog2(BufferDepth);
  localparam int CntW        = $clog2(BufferDepth + 1);
  localparam int AddrW       = 7;
  localparam int DataW       = 32;
  localparam int SizeW       = 5;
  localparam logic [4:0] ThresholdReset = 5'd10;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_ERASE = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_HIT    = 2'd0,
    KIND_MISS   = 2'd1,
    KIND_WRITE  = 2'd2,
    KIND_ERASE  = 2'd3
  } kind_t;

  typedef struct packed {
    logic              is_erase;
    logic [AddrW-1:0]  addr;
    logic [DataW-1:0]  data;
    logic [SizeW-1:0]  size;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN,
    ST_TRIM_HEAD,
    ST_TRIM_TAIL,
    ST_MARK,
    ST_DRAIN
  } state_t;

endpackage

### hw/rtl/storage_write_buffer.sv
// Write buffer with read forwarding in front of a storage backend. A command is
// taken when start is high and busy is low. A write or an erase that does not
// reach the flush threshold is stored at the accepting edge, and the block
// stays idle. A read walks the buffer newest first, one entry per cycle, until
// it finds the address or reaches the oldest entry, and its single result
// appears in the cycle after the walk ends. A flush, commanded or caused by the
// threshold, first reduces the buffer newest first: a write is checked against
// the covered-address map, and an erase is trimmed at its head and its tail
// against covered blocks, and the blocks it keeps are then marked in the map.
// The drain then walks the entries from the oldest up to the newest kept one
// and puts out the kept commands oldest first. Each result is on the outputs
// for one cycle under strobe, and the receiver cannot stall it. Configuration
// is taken only while the block is idle.
module storage_write_buffer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [6:0]  addr,
  input  logic [31:0] data,
  input  logic [4:0]  erase_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output logic        strobe,
  output logic [1:0]  kind,
  output logic [6:0]  out_addr,
  output logic [31:0] out_data,
  output logic [4:0]  out_size,
  output logic        last
);

  localparam int IdxW  = swb_pkg::IdxW;
  localparam int CntW  = swb_pkg::CntW;
  localparam int AddrW = swb_pkg::AddrW;
  localparam int SizeW = swb_pkg::SizeW;

  swb_pkg::entry_t entry_store [swb_pkg::BufferDepth];
  logic [swb_pkg::BufferDepth-1:0] keep;
  logic [AddrW-1:0] kaddr [swb_pkg::BufferDepth];
  logic [SizeW-1:0] ksize [swb_pkg::BufferDepth];

  swb_pkg::state_t state, state_next;
  logic [CntW-1:0] entry_count;
  logic [4:0]      flush_threshold;
  logic [IdxW-1:0] idx;
  logic [AddrW-1:0] req_addr;
  logic [AddrW:0]   cur_start;
  logic [SizeW-1:0] cur_left;
  logic [SizeW-1:0] mark_cnt;
  swb_pkg::entry_t  cur;

  logic             map_clear, map_set;
  logic [AddrW-1:0] map_set_addr, probe_addr;
  logic             probe_hit;

  assign cfg_ready = (state == swb_pkg::ST_IDLE);
  assign busy      = (state != swb_pkg::ST_IDLE);
  assign cur       = entry_store[idx];

  // Effective threshold clamped to one through the buffer depth.
  logic [CntW-1:0] thr;
  always_comb begin
    if (flush_threshold == 5'd0) begin
      thr = CntW'(1);
    end else if (32'(flush_threshold) > swb_pkg::BufferDepth) begin
      thr = CntW'(swb_pkg::BufferDepth);
    end else begin
      thr = CntW'(flush_threshold);
    end
  end

  // Erase size after saturation and clipping at the top of the address space.
  logic [SizeW-1:0] sat_size;
  logic [AddrW:0]   room;
  always_comb begin
    room = (AddrW+1)'(swb_pkg::AddrCount) - {1'b0, addr};
    sat_size = (32'(erase_size) > swb_pkg::MaxErase) ? SizeW'(swb_pkg::MaxErase) : erase_size;
    if ({{(AddrW+1-SizeW){1'b0}}, sat_size} > room) begin
      sat_size = SizeW'(room);
    end
  end

  // Slot for a new entry; a full buffer overwrites its top entry.
  logic [CntW-1:0] wr_count;
  assign wr_count = (32'(entry_count) >= swb_pkg::BufferDepth) ?
                    CntW'(swb_pkg::BufferDepth - 1) : entry_count;

  logic hit_write, hit_erase;
  logic [AddrW:0] erase_end;
  assign erase_end = {1'b0, cur.addr} + {{(AddrW+1-SizeW){1'b0}}, cur.size};
  assign hit_write = !cur.is_erase && cur.addr == req_addr;
  assign hit_erase = cur.is_erase && cur.addr <= req_addr &&
                     {1'b0, req_addr} < erase_end;

  // Map probe address: the head or tail block of the current erase, or a write.
  always_comb begin
    probe_addr = cur.addr;
    if (state == swb_pkg::ST_TRIM_HEAD) begin
      probe_addr = AddrW'(cur_start);
    end else if (state == swb_pkg::ST_TRIM_TAIL) begin
      probe_addr = AddrW'(cur_start + {{(AddrW+1-SizeW){1'b0}}, cur_left} - 1'b1);
    end
  end

  swb_cover_map u_map (
    .clk        (clk),
    .rst        (rst),
    .clear      (map_clear),
    .set_en     (map_set),
    .set_addr   (map_set_addr),
    .probe_addr (probe_addr),
    .probe_hit  (probe_hit)
  );

  // Whether any kept entry lies above the drain position, for the last flag.
  logic more_kept;
  always_comb begin
    more_kept = 1'b0;
    for (int k = 0; k < swb_pkg::BufferDepth; k++) begin
      if (k > int'(idx) && k < int'(entry_count) && keep[k]) begin
        more_kept = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    map_clear  = 1'b0;
    map_set    = 1'b0;
    map_set_addr = AddrW'(cur_start);
    unique case (state)
      swb_pkg::ST_IDLE: begin
        if (start) begin
          unique case (swb_pkg::op_t'(operation))
            swb_pkg::OP_READ:  state_next = swb_pkg::ST_READ;
            swb_pkg::OP_FLUSH: state_next = swb_pkg::ST_SCAN;
            default: begin
              if (wr_count + 1'b1 >= thr) begin
                state_next = swb_pkg::ST_SCAN;
              end
            end
          endcase
          map_clear = 1'b1;
        end
      end
      swb_pkg::ST_READ: begin
        if (entry_count == '0 || hit_write || hit_erase || idx == '0) begin
          state_next = swb_pkg::ST_IDLE;
        end
      end
      swb_pkg::ST_SCAN: begin
        if (entry_count == '0) begin
          state_next = swb_pkg::ST_IDLE;
        end else if (cur.is_erase) begin
          state_next = swb_pkg::ST_TRIM_HEAD;
        end else begin
          map_set = !probe_hit;
          map_set_addr = cur.addr;
          state_next = (idx == '0) ? swb_pkg::ST_DRAIN : swb_pkg::ST_SCAN;
        end
      end
      swb_pkg::ST_TRIM_HEAD: begin
        if (cur_left == '0 || !probe_hit) begin
          state_next = swb_pkg::ST_TRIM_TAIL;
        end
      end
      swb_pkg::ST_TRIM_TAIL: begin
        if (cur_left == '0 || !probe_hit) begin
          state_next = (cur_left != '0) ? swb_pkg::ST_MARK :
                       (idx == '0) ? swb_pkg::ST_DRAIN : swb_pkg::ST_SCAN;
        end
      end
      swb_pkg::ST_MARK: begin
        map_set = 1'b1;
        map_set_addr = AddrW'(cur_start + {{(AddrW+1-SizeW){1'b0}}, mark_cnt});
        if (mark_cnt + 1'b1 == cur_left) begin
          state_next = (idx == '0) ? swb_pkg::ST_DRAIN : swb_pkg::ST_SCAN;
        end
      end
      swb_pkg::ST_DRAIN: begin
        if (!more_kept) begin
          state_next = swb_pkg::ST_IDLE;
        end
      end
      default: state_next = swb_pkg::ST_IDLE;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= swb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      flush_threshold <= swb_pkg::ThresholdReset;
    end else if (cfg_valid && cfg_ready) begin
      flush_threshold <= cfg_data;
    end
  end

  // Entry store, count, walk index, per-entry flush results and output registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      strobe      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (state)
        swb_pkg::ST_IDLE: begin
          if (start) begin
            req_addr <= addr;
            if (swb_pkg::op_t'(operation) == swb_pkg::OP_READ ||
                swb_pkg::op_t'(operation) == swb_pkg::OP_FLUSH) begin
              idx <= IdxW'(entry_count - 1'b1);
            end else begin
              entry_store[wr_count[IdxW-1:0]].is_erase <=
                (swb_pkg::op_t'(operation) == swb_pkg::OP_ERASE);
              entry_store[wr_count[IdxW-1:0]].addr <= addr;
              entry_store[wr_count[IdxW-1:0]].data <=
                (swb_pkg::op_t'(operation) == swb_pkg::OP_ERASE) ? '0 : data;
              entry_store[wr_count[IdxW-1:0]].size <=
                (swb_pkg::op_t'(operation) == swb_pkg::OP_ERASE) ? sat_size : '0;
              entry_count <= wr_count + 1'b1;
              idx <= wr_count[IdxW-1:0];
            end
          end
        end
        swb_pkg::ST_READ: begin
          if (entry_count == '0 || hit_write || hit_erase || idx == '0) begin
            strobe   <= 1'b1;
            out_addr <= req_addr;
            out_size <= '0;
            last     <= 1'b1;
            if (entry_count != '0 && (hit_write || hit_erase)) begin
              kind     <= swb_pkg::KIND_HIT;
              out_data <= hit_write ? cur.data : '0;
            end else begin
              kind     <= swb_pkg::KIND_MISS;
              out_data <= '0;
            end
          end else begin
            idx <= idx - 1'b1;
          end
        end
        swb_pkg::ST_SCAN: begin
          if (entry_count == '0) begin
            entry_count <= '0;
          end else if (cur.is_erase) begin
            cur_start <= {1'b0, cur.addr};
            cur_left  <= cur.size;
            mark_cnt  <= '0;
          end else begin
            keep[idx]  <= !probe_hit;
            kaddr[idx] <= cur.addr;
            ksize[idx] <= '0;
            if (idx != '0) idx <= idx - 1'b1;
          end
        end
        swb_pkg::ST_TRIM_HEAD: begin
          if (cur_left != '0 && probe_hit) begin
            cur_start <= cur_start + 1'b1;
            cur_left  <= cur_left - 1'b1;
          end
        end
        swb_pkg::ST_TRIM_TAIL: begin
          if (cur_left != '0 && probe_hit) begin
            cur_left <= cur_left - 1'b1;
          end else begin
            keep[idx]  <= (cur_left != '0);
            kaddr[idx] <= AddrW'(cur_start);
            ksize[idx] <= cur_left;
            if (cur_left == '0 && idx != '0) idx <= idx - 1'b1;
          end
        end
        swb_pkg::ST_MARK: begin
          mark_cnt <= mark_cnt + 1'b1;
          if (mark_cnt + 1'b1 == cur_left && idx != '0) begin
            idx <= idx - 1'b1;
          end
        end
        swb_pkg::ST_DRAIN: begin
          if (keep[idx]) begin
            strobe   <= 1'b1;
            kind     <= cur.is_erase ? swb_pkg::KIND_ERASE : swb_pkg::KIND_WRITE;
            out_addr <= kaddr[idx];
            out_data <= cur.is_erase ? '0 : cur.data;
            out_size <= ksize[idx];
            last     <= !more_kept;
          end
          if (!more_kept) begin
            entry_count <= '0;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) <= swb_pkg::BufferDepth)
    else $error("entry count above buffer depth");
  a_busy_on_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy &&
     (operation == swb_pkg::OP_READ || operation == swb_pkg::OP_FLUSH)) |=> busy)
    else $error("accepted read or flush did not make the block busy");
  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cfg_ready)
    else $error("configuration open while busy");
  a_read_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind == swb_pkg::KIND_MISS) |-> last)
    else $error("read result without last");
`endif

endmodule

### hw/rtl/swb_cover_map.sv
// Covered-address map: one bit per block, cleared all at once, set one bit at a time.
module swb_cover_map (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  logic                    set_en,
  input  logic [swb_pkg::AddrW-1:0] set_addr,
  input  logic [swb_pkg::AddrW-1:0] probe_addr,
  output logic                    probe_hit
);

  logic [swb_pkg::AddrCount-1:0] covered;

  // Bit storage with a single-bit set per cycle.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      covered <= '0;
    end else if (set_en) begin
      covered[set_addr] <= 1'b1;
    end
  end

  assign probe_hit = covered[probe_addr];

endmodule

### tb/tb_storage_write_buffer.sv
`timescale 1ns / 1ps

module tb_storage_write_buffer;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  operation;
  logic [6:0]  addr;
  logic [31:0] data;
  logic [4:0]  erase_size;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;
  logic        strobe;
  logic [1:0]  kind;
  logic [6:0]  out_addr;
  logic [31:0] out_data;
  logic [4:0]  out_size;
  logic        last;

  storage_write_buffer uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .operation(operation), .addr(addr), .data(data), .erase_size(erase_size),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .strobe(strobe), .kind(kind), .out_addr(out_addr), .out_data(out_data),
    .out_size(out_size), .last(last)
  );

  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  addr;
    logic [31:0] data;
    logic [4:0]  size;
    logic        last;
  } bus_cmd_t;

  typedef struct {
    swb_pkg::op_t op;
    logic [6:0]   addr;
    logic [31:0]  data;
    logic [4:0]   size;
    logic         known;
    bus_cmd_t     res;
  } stim_row_t;

  // Shadow copy of the buffer state used for prediction.
  swb_pkg::entry_t shadow_buf [swb_pkg::BufferDepth];
  int          shadow_count;
  logic [4:0]  shadow_thr;
  bus_cmd_t    pending_cmds [$];
  int          errors;
  int          cycles;
  int          idle_pct;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Append one expected result at the back of the queue.
  function automatic void queue_cmd(bus_cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  // Reduce the buffer and queue the surviving commands, oldest first.
  function automatic void predict_flush();
    logic       covered [swb_pkg::AddrCount];
    logic       keep [swb_pkg::BufferDepth];
    int         kaddr [swb_pkg::BufferDepth];
    int         ksize [swb_pkg::BufferDepth];
    int         st, left, n;
    bus_cmd_t   c;
    for (int a = 0; a < swb_pkg::AddrCount; a++) covered[a] = 1'b0;
    for (int i = shadow_count - 1; i >= 0; i--) begin
      keep[i] = 1'b0;
      if (!shadow_buf[i].is_erase) begin
        if (!covered[shadow_buf[i].addr]) begin
          covered[shadow_buf[i].addr] = 1'b1;
          keep[i] = 1'b1;
          kaddr[i] = shadow_buf[i].addr;
          ksize[i] = 0;
        end
      end else begin
        st = shadow_buf[i].addr;
        left = shadow_buf[i].size;
        while (left > 0 && covered[st]) begin
          st++;
          left--;
        end
        while (left > 0 && covered[st + left - 1]) left--;
        if (left > 0) begin
          for (int a = st; a < st + left; a++) covered[a] = 1'b1;
          keep[i] = 1'b1;
          kaddr[i] = st;
          ksize[i] = left;
        end
      end
    end
    n = 0;
    for (int i = 0; i < shadow_count; i++) begin
      if (keep[i]) begin
        c.kind = shadow_buf[i].is_erase ? swb_pkg::KIND_ERASE : swb_pkg::KIND_WRITE;
        c.addr = 7'(kaddr[i]);
        c.data = shadow_buf[i].is_erase ? 32'd0 : shadow_buf[i].data;
        c.size = 5'(ksize[i]);
        c.last = 1'b0;
        queue_cmd(c);
        n++;
      end
    end
    if (n > 0) pending_cmds[pending_cmds.size() - 1].last = 1'b1;
    shadow_count = 0;
  endfunction

  // Work out the results of one accepted command.
  function automatic void predict_cmd(swb_pkg::op_t op, logic [6:0] a, logic [31:0] d,
                                      logic [4:0] sz);
    int       thr;
    int       s;
    bus_cmd_t c;
    logic     found;
    thr = shadow_thr;
    if (thr < 1) thr = 1;
    if (thr > swb_pkg::BufferDepth) thr = swb_pkg::BufferDepth;
    case (op)
      swb_pkg::OP_READ: begin
        found = 1'b0;
        c = '{kind: swb_pkg::KIND_MISS, addr: a, data: 32'd0, size: 5'd0, last: 1'b1};
        for (int i = shadow_count - 1; i >= 0 && !found; i--) begin
          if (!shadow_buf[i].is_erase && shadow_buf[i].addr == a) begin
            c.kind = swb_pkg::KIND_HIT;
            c.data = shadow_buf[i].data;
            found = 1'b1;
          end else if (shadow_buf[i].is_erase && shadow_buf[i].addr <= a &&
                       int'(a) < int'(shadow_buf[i].addr) + shadow_buf[i].size) begin
            c.kind = swb_pkg::KIND_HIT;
            found = 1'b1;
          end
        end
        queue_cmd(c);
      end
      swb_pkg::OP_FLUSH: predict_flush();
      default: begin
        if (shadow_count >= swb_pkg::BufferDepth) shadow_count = swb_pkg::BufferDepth - 1;
        shadow_buf[shadow_count].addr = a;
        if (op == swb_pkg::OP_WRITE) begin
          shadow_buf[shadow_count].is_erase = 1'b0;
          shadow_buf[shadow_count].data = d;
          shadow_buf[shadow_count].size = '0;
        end else begin
          s = sz;
          if (s > swb_pkg::MaxErase) s = swb_pkg::MaxErase;
          if (s > swb_pkg::AddrCount - int'(a)) s = swb_pkg::AddrCount - int'(a);
          shadow_buf[shadow_count].is_erase = 1'b1;
          shadow_buf[shadow_count].data = '0;
          shadow_buf[shadow_count].size = 5'(s);
        end
        shadow_count++;
        if (shadow_count >= thr) predict_flush();
      end
    endcase
  endfunction

  // Check each result against the oldest expected command.
  always @(posedge clk) begin
    bus_cmd_t want;
    if (!rst && strobe) begin
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d addr=%0d data=%h size=%0d last=%0d",
                 $time, kind, out_addr, out_data, out_size, last);
      end else begin
        want = pending_cmds.pop_front();
        if (kind !== want.kind || out_addr !== want.addr || out_data !== want.data ||
            out_size !== want.size || last !== want.last) begin
          errors++;
          $display("%0t: mismatch expected kind=%0d addr=%0d data=%h size=%0d last=%0d",
                   $time, want.kind, want.addr, want.data, want.size, want.last);
          $display("%0t:          actual   kind=%0d addr=%0d data=%h size=%0d last=%0d",
                   $time, kind, out_addr, out_data, out_size, last);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one command and hold it until the transfer. Start stays high after
  // the transfer; the next idle cycle or the drain wait takes it low.
  task automatic send_cmd(swb_pkg::op_t op, logic [6:0] a, logic [31:0] d,
                          logic [4:0] sz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    operation <= op;
    addr <= a;
    data <= d;
    erase_size <= sz;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_cmd(op, a, d, sz);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_cmds.size() != 0 || busy) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_threshold(logic [4:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    shadow_thr = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly writes and small erases over a narrow address window.
  task automatic send_random();
    int   r;
    swb_pkg::op_t op;
    logic [6:0] a;
    logic [4:0] sz;
    r = $urandom_range(99);
    op = r < 30 ? swb_pkg::OP_READ : r < 65 ? swb_pkg::OP_WRITE :
         r < 92 ? swb_pkg::OP_ERASE : swb_pkg::OP_FLUSH;
    a = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(23) + 100);
    sz = ($urandom_range(7) == 0) ? 5'($urandom) : 5'($urandom_range(6));
    send_cmd(op, a, $urandom, sz);
  endtask

  stim_row_t table_rows [$];
  bus_cmd_t  nr;

  task automatic add_row(swb_pkg::op_t op, logic [6:0] a, logic [31:0] d, logic [4:0] sz,
                         logic kn, bus_cmd_t r);
    stim_row_t row;
    row = '{op: op, addr: a, data: d, size: sz, known: kn, res: r};
    table_rows = {table_rows, row};
  endtask

  initial begin
    clk = 1'b0;
    errors = 0;
    cycles = 0;
    idle_pct = 0;
    shadow_count = 0;
    shadow_thr = swb_pkg::ThresholdReset;
    rst = 1'b1;
    start = 1'b0;
    operation = swb_pkg::OP_READ;
    addr = '0;
    data = '0;
    erase_size = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    nr = '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed table: extremes, every operation, zero-size and oversize erase.
    add_row(swb_pkg::OP_READ, 7'd127, 32'd0, 5'd0, 1'b1,
            '{kind: swb_pkg::KIND_MISS, addr: 7'd127, data: 32'd0, size: 5'd0,
              last: 1'b1});
    add_row(swb_pkg::OP_FLUSH, 7'd0, 32'd0, 5'd0, 1'b0, nr);
    add_row(swb_pkg::OP_WRITE, 7'd0, 32'hFFFF_FFFF, 5'd31, 1'b0, nr);
    add_row(swb_pkg::OP_READ, 7'd0, 32'd0, 5'd0, 1'b1,
            '{kind: swb_pkg::KIND_HIT, addr: 7'd0, data: 32'hFFFF_FFFF, size: 5'd0,
              last: 1'b1});
    add_row(swb_pkg::OP_ERASE, 7'd120, 32'hFFFF_FFFF, 5'd31, 1'b0, nr);
    add_row(swb_pkg::OP_READ, 7'd127, 32'd0, 5'd0, 1'b1,
            '{kind: swb_pkg::KIND_HIT, addr: 7'd127, data: 32'd0, size: 5'd0,
              last: 1'b1});
    add_row(swb_pkg::OP_ERASE, 7'd5, 32'd0, 5'd0, 1'b0, nr);
    add_row(swb_pkg::OP_READ, 7'd5, 32'd0, 5'd0, 1'b0, nr);
    add_row(swb_pkg::OP_WRITE, 7'd121, 32'h0000_0001, 5'd0, 1'b0, nr);
    add_row(swb_pkg::OP_WRITE, 7'd127, 32'h8000_0000, 5'd0, 1'b0, nr);
    add_row(swb_pkg::OP_ERASE, 7'd0, 32'd0, 5'd16, 1'b0, nr);
    add_row(swb_pkg::OP_WRITE, 7'd0, 32'h1234_5678, 5'd0, 1'b0, nr);
    add_row(swb_pkg::OP_FLUSH, 7'd127, 32'd0, 5'd0, 1'b0, nr);
    add_row(swb_pkg::OP_ERASE, 7'd3, 32'd0, 5'd4, 1'b0, nr);
    add_row(swb_pkg::OP_WRITE, 7'd3, 32'hA5A5_A5A5, 5'd0, 1'b0, nr);
    add_row(swb_pkg::OP_WRITE, 7'd6, 32'h5A5A_5A5A, 5'd0, 1'b0, nr);
    add_row(swb_pkg::OP_FLUSH, 7'd0, 32'd0, 5'd0, 1'b0, nr);

    foreach (table_rows[i]) begin
      if (table_rows[i].known) begin
        send_cmd(table_rows[i].op, table_rows[i].addr, table_rows[i].data,
                 table_rows[i].size);
        if (pending_cmds.size() == 0 || pending_cmds[pending_cmds.size() - 1] !==
            table_rows[i].res) begin
          errors++;
          $display("%0t: table row %0d expected %h", $time, i, table_rows[i].res);
        end
      end else begin
        send_cmd(table_rows[i].op, table_rows[i].addr, table_rows[i].data,
                 table_rows[i].size);
      end
    end

    // Random phases over several thresholds, extremes included.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: write_threshold(5'd1);
        1: write_threshold(5'd16);
        2: write_threshold(5'd0);
        3: write_threshold(5'd31);
        4: write_threshold(5'd4);
        5: write_threshold(5'($urandom_range(2, 15)));
        6: write_threshold(5'd10);
        default: write_threshold(5'($urandom));
      endcase
      idle_pct = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 64 : (ph % 4 == 2) ? 0 : 32;
      for (int k = 0; k < 26; k++) begin
        send_random();
        if (k == 14 && ph == 2) wait_drained();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
